// ----- sv/tbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_pkg: shared types and constants of the triple Bloom filter
// Command codes, register indexes, the queue entry between the front and the
// back part, and the status the back part reports to the front part.
// ----------------------------------------------------------------------------
package tbf_pkg;

  localparam int DEF_MAX_PRIMARY_WORDS = 65536;
  localparam int DEF_MAX_PROBES        = 32;

  localparam int CMD_W      = 2;
  localparam int HASH_W     = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int WORDS_W    = 17;
  localparam int COUNT_W    = 6;

  // Remainder-unit dividend width: the hash shifted right by at least four.
  localparam int QUOT_W     = 60;
  localparam int BIT_W      = 6;
  localparam int ENT_ADDR_W = 24;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIMARY_WORDS = 1'b0,
    CFG_HASH_COUNT    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                  clr;
    logic                  set;
    logic                  last;
    logic [ENT_ADDR_W-1:0] addr1;
    logic [BIT_W-1:0]      bit1;
    logic [ENT_ADDR_W-1:0] addr2;
    logic [BIT_W-1:0]      bit2;
    logic [ENT_ADDR_W-1:0] addr3;
    logic [BIT_W-1:0]      bit3;
  } probe_ent_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage
`default_nettype wire

// ----- sv/tbf_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_in_if / tbf_out_if: request and response channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface tbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] hash_first;
  logic [63:0] hash_second;
  logic [63:0] hash_third;
  modport source (output valid, cmd, hash_first, hash_second, hash_third, input ready);
  modport sink   (input valid, cmd, hash_first, hash_second, hash_third, output ready);
endinterface

interface tbf_out_if;
  logic valid;
  logic ready;
  logic present;
  modport source (output valid, present, input ready);
  modport sink   (input valid, present, output ready);
endinterface
`default_nettype wire

// ----- sv/tbf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tbf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/tbf_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_mod: bit-serial remainder unit
// Restoring reduction of a 60-bit dividend by the word count, one bit a cycle.
// ----------------------------------------------------------------------------
module tbf_mod #(
  parameter int WW = 17
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [tbf_pkg::QUOT_W-1:0] dividend,
  input  wire logic [WW-1:0]             divisor,
  output logic      [WW-1:0]             rem,
  output logic                           done
);
  import tbf_pkg::*;

  localparam int CW = $clog2(QUOT_W + 1);

  logic [QUOT_W-1:0] quot;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [WW:0]       trial;
  logic [WW:0]       trial_red;

  always_comb begin
    trial     = {rem, quot[QUOT_W-1]};
    trial_red = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(QUOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= quot << 1;
      rem  <= trial_red[WW-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- sv/tbf_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_queue: short probe queue
// Holds probe operations from the front part until the back part takes them.
// ----------------------------------------------------------------------------
module tbf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire tbf_pkg::probe_ent_t  push_data,
  input  wire logic                 pop,
  output tbf_pkg::probe_ent_t       head,
  output logic                      full,
  output logic                      empty
);
  import tbf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  probe_ent_t     slots [QUEUE_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tbf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_front: request front end
// Takes requests, steps the three probe sequences, reduces each probe index
// to a word and bit in each store and queues it; a clear is queued unreduced.
// ----------------------------------------------------------------------------
module tbf_front #(
  parameter int WW = 17,
  parameter int PW = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  tbf_in_if.sink                   req,
  input  wire logic [WW-1:0]       eff_words,
  input  wire logic [PW-1:0]       eff_probes,
  input  wire tbf_pkg::back_stat_t stat,
  input  wire logic                q_full,
  output logic                     q_push,
  output tbf_pkg::probe_ent_t      q_data
);
  import tbf_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t state, state_next;

  logic [HASH_W-1:0] h1, h2, h3;
  logic [HASH_W-1:0] x1, x2, x3;
  logic [HASH_W-1:0] x1_next, x2_next, x3_next;
  logic [WW-1:0]     words;
  logic [PW-1:0]     probes;
  logic [PW-1:0]     idx;
  logic              is_clr;
  logic              is_set;
  logic              accept;
  logic              advance;
  logic              last;
  logic              mod_start;
  logic [WW-1:0]     r1, r2, r3;
  logic              d1, d2, d3;
  logic [WW-1:0]     word2, word3;

  assign req.ready = (state == F_IDLE) && !stat.clearing;
  assign accept    = req.valid && req.ready;
  assign last      = is_clr || (({1'b0, idx} + 1'b1) == {1'b0, probes});
  assign q_push    = (state == F_PUSH) && !q_full;
  assign advance   = q_push && !last;
  assign mod_start = (accept && (req.cmd != CMD_CLEAR)) || advance;

  always_comb begin
    x1_next = x1;
    x2_next = x2;
    x3_next = x3;
    if (accept) begin
      x1_next = req.hash_first;
      x2_next = req.hash_second;
      x3_next = req.hash_third;
    end else if (advance) begin
      x1_next = x1 + h2;
      x2_next = x2 + h3;
      x3_next = x3 + h1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = (req.cmd == CMD_CLEAR) ? F_PUSH : F_MOD;
        end
      end
      F_MOD: begin
        if (d1 && d2 && d3) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (q_push) begin
          state_next = last ? F_IDLE : F_MOD;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    x1 <= x1_next;
    x2 <= x2_next;
    x3 <= x3_next;
    if (accept) begin
      h1     <= req.hash_first;
      h2     <= req.hash_second;
      h3     <= req.hash_third;
      is_clr <= (req.cmd == CMD_CLEAR);
      is_set <= (req.cmd == CMD_INSERT);
      words  <= eff_words;
      probes <= eff_probes;
      idx    <= '0;
    end else if (advance) begin
      idx <= idx + 1'b1;
    end
  end

  // The secondary index is reduced by 32 words' worth of bits and the
  // tertiary by 16, so the hashes enter the units shifted by 5 and 4.
  tbf_mod #(.WW(WW)) u_mod1 (
    .clk, .rst, .start(mod_start), .dividend(QUOT_W'(x1_next >> 6)),
    .divisor(words), .rem(r1), .done(d1)
  );
  tbf_mod #(.WW(WW)) u_mod2 (
    .clk, .rst, .start(mod_start), .dividend(QUOT_W'(x2_next >> 5)),
    .divisor(words), .rem(r2), .done(d2)
  );
  tbf_mod #(.WW(WW)) u_mod3 (
    .clk, .rst, .start(mod_start), .dividend(QUOT_W'(x3_next >> 4)),
    .divisor(words), .rem(r3), .done(d3)
  );

  always_comb begin
    word2        = r2 >> 1;
    word3        = r3 >> 2;
    q_data.clr   = is_clr;
    q_data.set   = is_set;
    q_data.last  = last;
    q_data.addr1 = ENT_ADDR_W'(r1);
    q_data.bit1  = x1[BIT_W-1:0];
    q_data.addr2 = ENT_ADDR_W'(word2);
    q_data.bit2  = {r2[0], x2[4:0]};
    q_data.addr3 = ENT_ADDR_W'(word3);
    q_data.bit3  = {r3[1:0], x3[3:0]};
  end

endmodule
`default_nettype wire

// ----- sv/tbf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_back: store access back end
// Runs queued probes as reads of all three stores plus a write on insert,
// collects the presence result; sweeps the stores to zero on reset and clear.
// ----------------------------------------------------------------------------
module tbf_back #(
  parameter int MAX_PRIMARY_WORDS = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tbf_pkg::probe_ent_t head,
  input  wire logic                q_empty,
  output logic                     q_pop,
  output tbf_pkg::back_stat_t      stat,
  tbf_out_if.source                rsp
);
  import tbf_pkg::*;

  localparam int D1 = MAX_PRIMARY_WORDS;
  localparam int D2 = MAX_PRIMARY_WORDS / 2;
  localparam int D3 = MAX_PRIMARY_WORDS / 4;
  localparam int A1 = (D1 > 1) ? $clog2(D1) : 1;
  localparam int A2 = (D2 > 1) ? $clog2(D2) : 1;
  localparam int A3 = (D3 > 1) ? $clog2(D3) : 1;

  typedef enum logic [3:0] {
    B_CLR  = 4'b0001,
    B_IDLE = 4'b0010,
    B_RD   = 4'b0100,
    B_WR   = 4'b1000
  } back_state_t;

  back_state_t state;

  logic [A1-1:0]   sweep;
  logic            report_clr;
  logic            acc;
  logic            hit;
  logic            out_free;
  probe_ent_t      ent;
  logic [63:0]     rd1, rd2, rd3;
  logic            we1, we2, we3;
  logic [A1-1:0]   wa1;
  logic [A2-1:0]   wa2;
  logic [A3-1:0]   wa3;
  logic [63:0]     wd1, wd2, wd3;

  assign out_free      = !rsp.valid || rsp.ready;
  assign q_pop         = (state == B_IDLE) && !q_empty && (!head.last || out_free);
  assign stat.clearing = (state == B_CLR);
  assign hit           = rd1[ent.bit1] && rd2[ent.bit2] && rd3[ent.bit3];

  always_comb begin
    if (state == B_CLR) begin
      we1 = 1'b1;
      we2 = ({1'b0, sweep} < (A1+1)'(D2));
      we3 = ({1'b0, sweep} < (A1+1)'(D3));
      wa1 = sweep;
      wa2 = A2'(sweep);
      wa3 = A3'(sweep);
      wd1 = '0;
      wd2 = '0;
      wd3 = '0;
    end else begin
      we1 = (state == B_WR) && ent.set;
      we2 = we1;
      we3 = we1;
      wa1 = A1'(ent.addr1);
      wa2 = A2'(ent.addr2);
      wa3 = A3'(ent.addr3);
      wd1 = rd1 | (64'd1 << ent.bit1);
      wd2 = rd2 | (64'd1 << ent.bit2);
      wd3 = rd3 | (64'd1 << ent.bit3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLR;
      sweep      <= '0;
      report_clr <= 1'b0;
      acc        <= 1'b1;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        B_CLR: begin
          sweep <= sweep + 1'b1;
          if ({1'b0, sweep} == (A1+1)'(D1 - 1)) begin
            state <= B_IDLE;
            if (report_clr) begin
              rsp.valid   <= 1'b1;
              rsp.present <= 1'b0;
            end
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            ent <= head;
            if (head.clr) begin
              state      <= B_CLR;
              sweep      <= '0;
              report_clr <= 1'b1;
            end else begin
              state <= B_RD;
            end
          end
        end
        B_RD: begin
          state <= B_WR;
        end
        B_WR: begin
          state <= B_IDLE;
          if (ent.last) begin
            rsp.valid   <= 1'b1;
            rsp.present <= acc && hit;
            acc         <= 1'b1;
          end else begin
            acc <= acc && hit;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  tbf_ram #(.WIDTH(64), .DEPTH(D1)) u_primary (
    .clk, .we(we1), .waddr(wa1), .wdata(wd1),
    .re(state == B_RD), .raddr(A1'(ent.addr1)), .rdata(rd1)
  );
  tbf_ram #(.WIDTH(64), .DEPTH(D2)) u_secondary (
    .clk, .we(we2), .waddr(wa2), .wdata(wd2),
    .re(state == B_RD), .raddr(A2'(ent.addr2)), .rdata(rd2)
  );
  tbf_ram #(.WIDTH(64), .DEPTH(D3)) u_tertiary (
    .clk, .we(we3), .waddr(wa3), .wdata(wd3),
    .re(state == B_RD), .raddr(A3'(ent.addr3)), .rdata(rd3)
  );

endmodule
`default_nettype wire

// ----- sv/triple_bloom_filter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triple_bloom_filter_unit: Bloom filter over three bit stores
// Requests arrive on req (command and three key hashes); each gives exactly
// one transfer on rsp carrying present. Check and insert run hash_count
// probes; each probe reduces three indices in bit-serial remainder units
// and then reads the three stores behind the front, with a write-back on
// insert. The front takes a new request once the last probe of the one
// before is queued, which can be before that request's response. The
// remainder units set the rate; the store access runs behind a four-entry
// queue.
// A clear command sweeps all stores, one word a cycle, and then answers
// with present low.
// After reset the same sweep runs with req.ready low; configuration writes
// are taken throughout. The result sits in an output register; while rsp
// is stalled the front keeps reducing the next item and stops only when the
// queue fills. Registers: 0 primary_words, 1 hash_count, written through
// cfg_we, cfg_index and cfg_data.
// ----------------------------------------------------------------------------
module triple_bloom_filter_unit #(
  parameter int MAX_PRIMARY_WORDS = tbf_pkg::DEF_MAX_PRIMARY_WORDS,
  parameter int MAX_PROBES        = tbf_pkg::DEF_MAX_PROBES
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  tbf_in_if.sink                                req,
  tbf_out_if.source                             rsp,
  input  wire logic                             cfg_we,
  input  wire logic [tbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tbf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tbf_pkg::*;

  localparam int WW = $clog2(MAX_PRIMARY_WORDS + 1);
  localparam int PW = $clog2(MAX_PROBES + 1);

  logic [WORDS_W-1:0] primary_words;
  logic [COUNT_W-1:0] hash_count;
  logic [31:0]        wc, kc;
  logic [WW-1:0]      eff_words;
  logic [PW-1:0]      eff_probes;
  back_stat_t         stat;
  probe_ent_t         q_data, q_head;
  logic               q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_words <= WORDS_W'(65536);
      hash_count    <= COUNT_W'(7);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRIMARY_WORDS: primary_words <= cfg_data[WORDS_W-1:0];
        CFG_HASH_COUNT:    hash_count    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wc = 32'(primary_words);
    if (wc < 32'd4) begin
      wc = 32'd4;
    end
    if (wc > 32'(MAX_PRIMARY_WORDS)) begin
      wc = 32'(MAX_PRIMARY_WORDS);
    end
    wc = wc & ~32'd3;
    kc = 32'(hash_count);
    if (kc < 32'd1) begin
      kc = 32'd1;
    end
    if (kc > 32'(MAX_PROBES)) begin
      kc = 32'(MAX_PROBES);
    end
    eff_words  = WW'(wc);
    eff_probes = PW'(kc);
  end

  tbf_front #(.WW(WW), .PW(PW)) u_front (
    .clk, .rst, .req, .eff_words, .eff_probes, .stat,
    .q_full, .q_push, .q_data
  );

  tbf_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_data), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  tbf_back #(.MAX_PRIMARY_WORDS(MAX_PRIMARY_WORDS)) u_back (
    .clk, .rst, .head(q_head), .q_empty, .q_pop, .stat, .rsp
  );

endmodule
`default_nettype wire

// ----- sv/tbf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbf_checker: port-level checks of the triple Bloom filter
// Watches the channel handshakes of the top level over time.
// ----------------------------------------------------------------------------
module tbf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic rsp_present
);

  // The stores are swept after reset, so no request is taken straight away.
  a_no_req_after_rst: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready right after reset");

  a_no_rsp_after_rst: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is still being reduced");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_present))
    else $error("stalled response dropped or changed");

endmodule

bind triple_bloom_filter_unit tbf_checker u_tbf_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_present(rsp.present)
);
`default_nettype wire
